// ===== rtl/dtq_pkg.sv =====
// Package for the deadline timer queue: opcodes, status codes, queue item types.
// Used by every module in rtl/.
`timescale 1ns / 1ps
package dtq_pkg;
  localparam int Capacity = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam logic [30:0] WaitMax = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_CANCEL = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_FULL = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED = 3'd4,
    ST_NONE_DUE = 3'd5
  } status_t;

  // Command handed from the front end to the list engine.
  typedef struct packed {
    opcode_t op;
    logic [63:0] now;
    logic [63:0] deadline;
    logic [3:0] handle;
  } cmd_t;

  typedef struct packed {
    status_t status;
    logic [3:0] handle;
    logic [63:0] deadline;
    logic [30:0] wait_time;
    logic queue_empty;
    logic last;
  } res_t;

  typedef enum logic [0:0] {
    EN_IDLE = 1'b0,
    EN_POP = 1'b1
  } eng_state_t;
endpackage

// ===== rtl/dtq_front.sv =====
// Front end: accepts input items, computes the deadline, drops unused opcodes,
// and pushes commands into a two-entry queue. Depends on dtq_pkg.
`timescale 1ns / 1ps
module dtq_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [103:0] in_tdata,
  output logic cmd_valid,
  input  logic cmd_ready,
  output dtq_pkg::cmd_t cmd
);
  dtq_pkg::cmd_t q_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;
  dtq_pkg::cmd_t c_in;
  logic push, pop;

  // Decode the packed request.
  always_comb begin
    c_in.op = dtq_pkg::opcode_t'(in_tdata[1:0]);
    c_in.now = in_tdata[65:2];
    c_in.deadline = in_tdata[65:2] + {32'd0, in_tdata[97:66]};
    c_in.handle = in_tdata[101:98];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready && (c_in.op != dtq_pkg::OP_NONE);
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("bad count");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty");
`endif
endmodule

// ===== rtl/dtq_engine.sv =====
// Back end: shift-register sorted list of deadlines and handles, one insert,
// remove or pop per cycle while the output register is free. Depends on dtq_pkg.
`timescale 1ns / 1ps
module dtq_engine (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  dtq_pkg::cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output dtq_pkg::res_t res
);
  localparam int N = dtq_pkg::Capacity;
  localparam int IW = dtq_pkg::IdxW;
  localparam int CW = dtq_pkg::CntW;

  logic [63:0] dl_r [N];
  logic [3:0] hd_r [N];
  logic [CW-1:0] cnt_r;
  logic [15:0] used_r;
  dtq_pkg::eng_state_t st_r, st_nxt;
  logic [63:0] now_r;
  logic [4:0] npop_r;
  logic oval_r;
  dtq_pkg::res_t res_r;

  logic out_free, take, do_pop;
  logic [N-1:0] occ, gt, hit;
  logic [4:0] free_h;
  logic found, full;
  logic [IW-1:0] hit_pos;
  logic [63:0] cur_now;
  // New list state for wait/empty computation.
  logic [CW-1:0] cnt_n;
  logic [63:0] head_n;
  logic [63:0] diff;
  logic [30:0] wait_v;
  logic due_next;
  dtq_pkg::res_t r_n;
  logic ins, rem, sh;

  assign out_free = !oval_r || out_ready;
  assign cmd_ready = (st_r == dtq_pkg::EN_IDLE) && out_free;
  assign take = cmd_valid && cmd_ready;
  assign do_pop = (st_r == dtq_pkg::EN_POP) && out_free;
  assign cur_now = (st_r == dtq_pkg::EN_POP) ? now_r : cmd.now;

  // Per-slot compares: occupancy, later deadline, handle match.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      occ[i] = (CW'(i) < cnt_r);
      gt[i] = occ[i] && (dl_r[i] > cmd.deadline);
      hit[i] = occ[i] && (hd_r[i] == cmd.handle);
    end
  end

  // Lowest free handle.
  always_comb begin
    free_h = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (!used_r[i]) free_h = 5'(i);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit[i]) hit_pos = IW'(i);
    end
  end

  assign found = used_r[cmd.handle] && (hit != '0);
  assign full = (cnt_r == CW'(N)) || free_h[4];
  assign ins = take && cmd.op == dtq_pkg::OP_ADD && !full;
  assign rem = take && cmd.op == dtq_pkg::OP_CANCEL && found;
  assign sh = (take && cmd.op == dtq_pkg::OP_ADVANCE && cnt_r != '0 &&
               dl_r[0] <= cmd.now) || (do_pop);

  // Count and head after this step.
  always_comb begin
    cnt_n = cnt_r;
    head_n = dl_r[0];
    if (ins) begin
      cnt_n = cnt_r + 1'b1;
      if (gt[0] || cnt_r == '0) head_n = cmd.deadline;
    end else if (rem) begin
      cnt_n = cnt_r - 1'b1;
      if (hit_pos == '0) head_n = dl_r[1];
    end else if (sh) begin
      cnt_n = cnt_r - 1'b1;
      head_n = dl_r[1];
    end
  end

  assign diff = head_n - cur_now;
  always_comb begin
    if (cnt_n == '0) wait_v = dtq_pkg::WaitMax;
    else if (head_n <= cur_now) wait_v = '0;
    else if (diff[63:31] != '0) wait_v = dtq_pkg::WaitMax;
    else wait_v = diff[30:0];
  end
  assign due_next = (cnt_n != '0) && (head_n <= cur_now);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      dtq_pkg::EN_IDLE: if (take && sh && due_next) st_nxt = dtq_pkg::EN_POP;
      dtq_pkg::EN_POP: if (do_pop && (!due_next || npop_r == 5'd15))
        st_nxt = dtq_pkg::EN_IDLE;
      default: st_nxt = dtq_pkg::EN_IDLE;
    endcase
  end

  // Result formation.
  always_comb begin
    r_n.wait_time = wait_v;
    r_n.queue_empty = (cnt_n == '0);
    r_n.last = 1'b1;
    r_n.handle = '0;
    r_n.deadline = '0;
    r_n.status = dtq_pkg::ST_NONE_DUE;
    if (sh) begin
      r_n.status = dtq_pkg::ST_FIRED;
      r_n.handle = hd_r[0];
      r_n.deadline = dl_r[0];
      r_n.last = !due_next ||
        ((st_r == dtq_pkg::EN_POP) ? (npop_r == 5'd15) : 1'b0);
    end else begin
      case (cmd.op)
        dtq_pkg::OP_ADD: begin
          r_n.status = full ? dtq_pkg::ST_FULL : dtq_pkg::ST_ADDED;
          r_n.handle = full ? 4'd0 : free_h[3:0];
          r_n.deadline = full ? 64'd0 : cmd.deadline;
        end
        dtq_pkg::OP_CANCEL: begin
          r_n.status = found ? dtq_pkg::ST_CANCELLED : dtq_pkg::ST_NOT_FOUND;
          r_n.handle = cmd.handle;
          r_n.deadline = found ? dl_r[hit_pos] : 64'd0;
        end
        default: r_n.status = dtq_pkg::ST_NONE_DUE;
      endcase
    end
  end

  // Sorted list shift register.
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (ins) begin
        if (gt[i]) begin
          if (i > 0 && !gt[i-1]) begin
            dl_r[i] <= cmd.deadline;
            hd_r[i] <= free_h[3:0];
          end else if (i > 0) begin
            dl_r[i] <= dl_r[i-1];
            hd_r[i] <= hd_r[i-1];
          end else begin
            dl_r[i] <= cmd.deadline;
            hd_r[i] <= free_h[3:0];
          end
        end else if (CW'(i) == cnt_r) begin
          if (i > 0 && gt[i-1]) begin
            dl_r[i] <= dl_r[i-1];
            hd_r[i] <= hd_r[i-1];
          end else begin
            dl_r[i] <= cmd.deadline;
            hd_r[i] <= free_h[3:0];
          end
        end
      end else if ((rem && IW'(i) >= hit_pos) || sh) begin
        if (i < N - 1) begin
          dl_r[i] <= dl_r[i+1];
          hd_r[i] <= hd_r[i+1];
        end
      end
    end
    if (take) now_r <= cmd.now;
    if (out_free && (take || do_pop)) res_r <= r_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      used_r <= '0;
      st_r <= dtq_pkg::EN_IDLE;
      oval_r <= 1'b0;
      npop_r <= '0;
    end else begin
      cnt_r <= cnt_n;
      st_r <= st_nxt;
      if (ins) used_r[free_h[3:0]] <= 1'b1;
      if (take && cmd.op == dtq_pkg::OP_CANCEL) used_r[cmd.handle] <= 1'b0;
      if (sh) used_r[hd_r[0]] <= 1'b0;
      if (take) npop_r <= 5'd1;
      else if (do_pop) npop_r <= npop_r + 5'd1;
      if (take || do_pop) oval_r <= 1'b1;
      else if (out_ready) oval_r <= 1'b0;
    end
  end

  assign out_valid = oval_r;
  assign res = res_r;

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(N)) else $error("count above capacity");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(res_r)) else $error("result changed");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == dtq_pkg::EN_POP |-> !cmd_ready) else $error("took command in pop");
`endif
endmodule

// ===== rtl/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: front end, command queue, list engine.
// Depends on dtq_pkg, dtq_front and dtq_engine.
`timescale 1ns / 1ps
// Usage:
// The in_ channel takes one request per handshake: add, cancel or advance.
// Opcode 3 is dropped without a result. Every add and cancel gives one
// result; an advance gives one result per due entry (at most 16), earliest
// first, with out_tlast on the final one, or a single none-due result.
// A request passes the command queue and then the output register before its
// first result. The engine handles one request at a time; an advance gives
// its results in turn, as the sorted shift-register list shifts once per pop.
// A two-entry command queue lets the input keep flowing while the engine
// works. When the receiver stalls, the output register holds its result and
// the engine waits; the queue then fills and in_tready falls.
// Reset empties the list, frees all handles and drops queued requests.
module deadline_timer_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [103:0] in_tdata,   // opcode[1:0], now[65:2], offset[97:66], cancel_handle[101:98]
  output logic out_tvalid,
  input  logic out_tready,
  output logic [103:0] out_tdata,  // status[2:0], handle[6:3], deadline[70:7], wait_time[101:71], queue_empty[102]
  output logic out_tlast
);
  logic cmd_valid, cmd_ready;
  dtq_pkg::cmd_t cmd;
  dtq_pkg::res_t res;

  dtq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  dtq_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_valid(out_tvalid), .out_ready(out_tready), .res(res)
  );

  // Pack the result.
  assign out_tdata = {1'b0, res.queue_empty, res.wait_time, res.deadline,
                      res.handle, res.status};
  assign out_tlast = res.last;
endmodule
